>>> rtl/puti_pkg.sv
// Shared types, constants and arithmetic steps for the primitive UV texel index block.
// No dependencies; used by puti_angle and primitive_uv_texel_index_top.
`timescale 1ns / 1ps

package puti_pkg;

   // texture and coordinate formats
   localparam int MAX_TEX_DIM     = 4096;
   localparam int COORD_FRAC_BITS = 14;
   localparam int DIM_W           = 13;
   localparam int TEXEL_W         = 12;
   localparam int INDEX_W         = 24;
   localparam int RAW_W           = 16;

   // u,v carry 16 fraction bits
   localparam int UV_FRAC  = 16;
   localparam int UV_ONE   = 1 << UV_FRAC;
   localparam int UV_HALF  = UV_ONE / 2;
   localparam int LONG_W   = 28;
   localparam int Q16_SHL  = (UV_FRAC > COORD_FRAC_BITS) ? UV_FRAC - COORD_FRAC_BITS : 0;
   localparam int Q16_SHR  = (COORD_FRAC_BITS > UV_FRAC) ? COORD_FRAC_BITS - UV_FRAC : 0;
   localparam int UVS_W    = 18;
   localparam int PROD_W   = 26;

   // angles in 1/65536 turn
   localparam int TURN_HALF    = 32768;
   localparam int TURN_FULL    = 65536;
   localparam int ANGLE_W      = 18;
   localparam int COORD_W      = 18;
   localparam int CORDIC_W     = 46;
   localparam int CORDIC_SCALE = 24;
   localparam int CORDIC_STEPS = 15;
   localparam int CORDIC_PER   = 3;
   localparam int CORDIC_STAGES = (CORDIC_STEPS + CORDIC_PER - 1) / CORDIC_PER;

   // square root, one result bit per step
   localparam int ISQ_W      = 35;
   localparam int ISQ_STEPS  = 17;
   localparam int ISQ_PER    = 3;
   localparam int ISQ_STAGES = (ISQ_STEPS + ISQ_PER - 1) / ISQ_PER;

   // primitive kinds
   localparam logic [1:0] MODE_CUBE     = 2'd0;
   localparam logic [1:0] MODE_SPHERE   = 2'd1;
   localparam logic [1:0] MODE_CYLINDER = 2'd2;

   // cube faces; on cylinder and cone a cap from FACE_CAP_MIN up
   localparam logic [2:0] FACE_POS_X   = 3'd0;
   localparam logic [2:0] FACE_NEG_X   = 3'd1;
   localparam logic [2:0] FACE_POS_Y   = 3'd2;
   localparam logic [2:0] FACE_NEG_Y   = 3'd3;
   localparam logic [2:0] FACE_POS_Z   = 3'd4;
   localparam logic [2:0] FACE_NEG_Z   = 3'd5;
   localparam logic [2:0] FACE_CAP_MIN = 3'd2;

   typedef struct packed {
      logic [1:0]              mode;
      logic [2:0]              face;
      logic signed [RAW_W-1:0] coord_x;
      logic signed [RAW_W-1:0] coord_y;
      logic signed [RAW_W-1:0] coord_z;
      logic [DIM_W-1:0]        tex_width;
      logic [DIM_W-1:0]        tex_height;
      logic [7:0]              repeat_u;
      logic [7:0]              repeat_v;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0] texel_index;
      logic [TEXEL_W-1:0] texel_column;
      logic [TEXEL_W-1:0] texel_row;
   } rsp_type;

   typedef struct packed {
      logic signed [CORDIC_W-1:0] x;
      logic signed [CORDIC_W-1:0] y;
      logic signed [ANGLE_W-1:0]  ang;
   } cordic_state_type;

   typedef struct packed {
      logic [ISQ_W-1:0] n;
      logic [ISQ_W-1:0] res;
   } isq_state_type;

   // arctangent of 2^-i in 1/65536 turn
   function automatic logic signed [ANGLE_W-1:0] turn_step(input int i);
      logic signed [ANGLE_W-1:0] t;
      case (i)
         0:  t = 18'sd8192;
         1:  t = 18'sd4836;
         2:  t = 18'sd2555;
         3:  t = 18'sd1297;
         4:  t = 18'sd651;
         5:  t = 18'sd326;
         6:  t = 18'sd163;
         7:  t = 18'sd81;
         8:  t = 18'sd41;
         9:  t = 18'sd20;
         10: t = 18'sd10;
         11: t = 18'sd5;
         12: t = 18'sd3;
         13: t = 18'sd1;
         14: t = 18'sd1;
         default: t = 18'sd0;
      endcase
      return t;
   endfunction

   // one vectoring rotation
   function automatic cordic_state_type cordic_step(input cordic_state_type st, input int i);
      logic signed [CORDIC_W-1:0] dx;
      logic signed [CORDIC_W-1:0] dy;
      cordic_state_type           r;
      dx = st.y >>> i;
      dy = st.x >>> i;
      r  = st;
      if (st.y > 0) begin
         r.x   = st.x + dx;
         r.y   = st.y - dy;
         r.ang = st.ang + turn_step(i);
      end else begin
         r.x   = st.x - dx;
         r.y   = st.y + dy;
         r.ang = st.ang - turn_step(i);
      end
      return r;
   endfunction

   // one restoring square-root step, bit 2^(2*(ISQ_STEPS-1-k))
   function automatic isq_state_type isq_step(input isq_state_type st, input int k);
      logic [ISQ_W-1:0] bitv;
      logic [ISQ_W-1:0] trial;
      isq_state_type    r;
      bitv  = ISQ_W'(1) << (2 * (ISQ_STEPS - 1 - k));
      trial = st.res + bitv;
      r     = st;
      if (st.n >= trial) begin
         r.n   = st.n - trial;
         r.res = (st.res >> 1) + bitv;
      end else begin
         r.res = st.res >> 1;
      end
      return r;
   endfunction

   // raw coordinate to 16 fraction bits, floor on a right shift
   function automatic logic signed [LONG_W-1:0] to_q16(input logic signed [RAW_W-1:0] raw);
      logic signed [LONG_W-1:0] w;
      w = LONG_W'(raw);
      return (w <<< Q16_SHL) >>> Q16_SHR;
   endfunction

   // sphere arcsine argument 2*y, saturated to +-1.0
   function automatic logic signed [COORD_W-1:0] sphere_arg(input logic signed [RAW_W-1:0] yr);
      logic signed [LONG_W-1:0] s;
      s = to_q16(yr) <<< 1;
      if (s > LONG_W'(UV_ONE)) s = LONG_W'(UV_ONE);
      if (s < -LONG_W'(UV_ONE)) s = -LONG_W'(UV_ONE);
      return COORD_W'(s);
   endfunction

   // texture size into 1..MAX_TEX_DIM
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
      logic [DIM_W-1:0] r;
      r = d;
      if (d == '0) r = DIM_W'(1);
      if (d > DIM_W'(MAX_TEX_DIM)) r = DIM_W'(MAX_TEX_DIM);
      return r;
   endfunction

endpackage

>>> rtl/primitive_uv_texel_index_top.sv
// Top level of the primitive UV texel index block: hit point to texel column, row and index.
// Depends on puti_pkg and puti_angle.
`timescale 1ns / 1ps

// One request is taken every cycle; busy never rises and the block has no way to hold
// results, so the receiver must take each rsp_valid strobe as it comes. A result shows on
// rsp_data for one cycle. The pipeline depth is set by the sphere path: an input stage, a
// square-root multiply, six square-root stages of up to three result bits each, five
// CORDIC stages of three rotations each, then u,v selection and four texel stages
// (repeat multiply, texel multiply, clamp, index).
module primitive_uv_texel_index_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  puti_pkg::req_type req_data,
   output logic              rsp_valid,
   output puti_pkg::rsp_type rsp_data
);

   localparam int SIDE_LAST = 1 + puti_pkg::ISQ_STAGES + puti_pkg::CORDIC_STAGES;
   localparam int ISQ_ALIGN = 1 + puti_pkg::ISQ_STAGES;

   typedef struct packed {
      logic              valid;
      puti_pkg::req_type req;
   } side_type;

   typedef struct packed {
      logic                                 valid;
      logic                                 tiled;
      logic signed [puti_pkg::UVS_W-1:0]    u;
      logic signed [puti_pkg::UVS_W-1:0]    tv;
      logic [puti_pkg::DIM_W-1:0]           w;
      logic [puti_pkg::DIM_W-1:0]           h;
      logic [7:0]                           ru;
      logic [7:0]                           rv;
   } uv_type;

   typedef struct packed {
      logic                                 valid;
      logic                                 tiled;
      logic signed [puti_pkg::PROD_W-1:0]   qu;
      logic signed [puti_pkg::PROD_W-1:0]   qv;
      logic [puti_pkg::DIM_W-1:0]           w;
      logic [puti_pkg::DIM_W-1:0]           h;
   } rep_type;

   typedef struct packed {
      logic                                 valid;
      logic                                 col_zero;
      logic                                 col_top;
      logic                                 row_zero;
      logic                                 row_top;
      logic [28:0]                          col_prod;
      logic [28:0]                          row_prod;
      logic [puti_pkg::DIM_W-1:0]           w;
      logic [puti_pkg::DIM_W-1:0]           h;
   } tex_type;

   typedef struct packed {
      logic                                 valid;
      logic [puti_pkg::TEXEL_W-1:0]         col;
      logic [puti_pkg::TEXEL_W-1:0]         row;
      logic [puti_pkg::DIM_W-1:0]           w;
   } cr_type;

   side_type                   side_in [SIDE_LAST+1];
   side_type                   side_ff [SIDE_LAST+1];
   puti_pkg::isq_state_type    isq_in  [puti_pkg::ISQ_STAGES+1];
   puti_pkg::isq_state_type    isq_ff  [puti_pkg::ISQ_STAGES+1];

   logic signed [puti_pkg::COORD_W-1:0] s_in;
   logic signed [35:0]                  s_sq;
   logic signed [puti_pkg::COORD_W-1:0] per_x, per_z, sph_c, sph_s;
   logic signed [puti_pkg::ANGLE_W-1:0] per_ang, sph_ang;

   uv_type  uv_in,  uv_ff;
   rep_type rep_in, rep_ff;
   tex_type tex_in, tex_ff;
   cr_type  cr_in,  cr_ff;
   logic    out_valid_in, out_valid_ff;
   puti_pkg::rsp_type out_in, out_ff;

   assign busy = 1'b0;

   // request sideband, shifted every cycle alongside the arithmetic
   always_comb begin
      side_in[0].valid = start;
      side_in[0].req   = req_data;
      for (int i = 1; i <= SIDE_LAST; i++) begin
         side_in[i] = side_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i <= SIDE_LAST; i++) begin
         if (reset) begin
            side_ff[i] <= '0;
         end else begin
            side_ff[i] <= side_in[i];
         end
      end
   end

   // radicand 1 - s*s for the sphere cosine
   always_comb begin
      s_in          = puti_pkg::sphere_arg(side_ff[0].req.coord_y);
      s_sq          = 36'(s_in) * 36'(s_in);
      isq_in[0].n   = (puti_pkg::ISQ_W'(1) << (2 * puti_pkg::UV_FRAC))
                      - puti_pkg::ISQ_W'(s_sq);
      isq_in[0].res = '0;
   end

   // square root, up to three result bits per stage
   for (genvar g = 1; g <= puti_pkg::ISQ_STAGES; g++) begin : g_isq
      always_comb begin
         puti_pkg::isq_state_type acc;
         acc = isq_ff[g-1];
         for (int k = 0; k < puti_pkg::ISQ_PER; k++) begin
            if ((g - 1) * puti_pkg::ISQ_PER + k < puti_pkg::ISQ_STEPS) begin
               acc = puti_pkg::isq_step(acc, (g - 1) * puti_pkg::ISQ_PER + k);
            end
         end
         isq_in[g] = acc;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i <= puti_pkg::ISQ_STAGES; i++) begin
         isq_ff[i] <= isq_in[i];
      end
   end

   // angle units: perimeter on raw x,z, sphere on (cos, sin)
   always_comb begin
      per_x = puti_pkg::COORD_W'(side_ff[ISQ_ALIGN].req.coord_x);
      per_z = puti_pkg::COORD_W'(side_ff[ISQ_ALIGN].req.coord_z);
      sph_c = puti_pkg::COORD_W'(isq_ff[puti_pkg::ISQ_STAGES].res);
      sph_s = puti_pkg::sphere_arg(side_ff[ISQ_ALIGN].req.coord_y);
   end

   puti_angle u_per_angle (
      .clock     (clock),
      .in_x      (per_x),
      .in_y      (per_z),
      .out_angle (per_ang)
   );

   puti_angle u_sph_angle (
      .clock     (clock),
      .in_x      (sph_c),
      .in_y      (sph_s),
      .out_angle (sph_ang)
   );

   // u,v selection and range limits
   always_comb begin
      puti_pkg::req_type        rq;
      logic signed [puti_pkg::LONG_W-1:0] x16, y16, z16, pu, sv, u, v, tv;
      rq  = side_ff[SIDE_LAST].req;
      x16 = puti_pkg::to_q16(rq.coord_x);
      y16 = puti_pkg::to_q16(rq.coord_y);
      z16 = puti_pkg::to_q16(rq.coord_z);

      // perimeter u, pole when x and z are both zero
      if (rq.coord_x == '0 && rq.coord_z == '0) begin
         pu = puti_pkg::LONG_W'(puti_pkg::UV_HALF);
      end else if (per_ang < 0) begin
         pu = -puti_pkg::LONG_W'(per_ang);
      end else begin
         pu = puti_pkg::LONG_W'(puti_pkg::UV_ONE) - puti_pkg::LONG_W'(per_ang);
      end
      sv = (puti_pkg::LONG_W'(sph_ang) <<< 1) + puti_pkg::LONG_W'(puti_pkg::UV_HALF);

      if (rq.mode >= puti_pkg::MODE_CYLINDER) begin
         if (rq.face >= puti_pkg::FACE_CAP_MIN) begin
            u = x16 + puti_pkg::LONG_W'(puti_pkg::UV_HALF);
            v = z16 + puti_pkg::LONG_W'(puti_pkg::UV_HALF);
         end else begin
            u = pu;
            v = y16 + puti_pkg::LONG_W'(puti_pkg::UV_HALF);
         end
      end else if (rq.mode == puti_pkg::MODE_SPHERE) begin
         u = pu;
         v = sv;
      end else begin
         case (rq.face)
            puti_pkg::FACE_POS_X: begin u = -z16; v = y16;  end
            puti_pkg::FACE_NEG_X: begin u = z16;  v = y16;  end
            puti_pkg::FACE_POS_Y: begin u = x16;  v = -z16; end
            puti_pkg::FACE_NEG_Y: begin u = x16;  v = z16;  end
            puti_pkg::FACE_POS_Z: begin u = x16;  v = y16;  end
            puti_pkg::FACE_NEG_Z: begin u = -x16; v = y16;  end
            default:              begin u = '0;   v = '0;   end
         endcase
         u = u + puti_pkg::LONG_W'(puti_pkg::UV_HALF);
         v = v + puti_pkg::LONG_W'(puti_pkg::UV_HALF);
      end

      // negative u or 1-v always lands on texel zero, so pin them at -1
      if (u > puti_pkg::LONG_W'(puti_pkg::UV_ONE)) u = puti_pkg::LONG_W'(puti_pkg::UV_ONE);
      if (u < 0) u = -puti_pkg::LONG_W'(1);
      if (v < 0) v = '0;
      tv = puti_pkg::LONG_W'(puti_pkg::UV_ONE) - v;
      if (tv < 0) tv = -puti_pkg::LONG_W'(1);

      uv_in.valid = side_ff[SIDE_LAST].valid;
      uv_in.tiled = (rq.repeat_u != 8'd1) || (rq.repeat_v != 8'd1);
      uv_in.u     = puti_pkg::UVS_W'(u);
      uv_in.tv    = puti_pkg::UVS_W'(tv);
      uv_in.w     = puti_pkg::clamp_dim(rq.tex_width);
      uv_in.h     = puti_pkg::clamp_dim(rq.tex_height);
      uv_in.ru    = rq.repeat_u;
      uv_in.rv    = rq.repeat_v;
   end

   // repeat multiply
   always_comb begin
      rep_in.valid = uv_ff.valid;
      rep_in.tiled = uv_ff.tiled;
      rep_in.qu    = puti_pkg::PROD_W'(uv_ff.u) * puti_pkg::PROD_W'($signed({1'b0, uv_ff.ru}));
      rep_in.qv    = puti_pkg::PROD_W'(uv_ff.tv) * puti_pkg::PROD_W'($signed({1'b0, uv_ff.rv}));
      rep_in.w     = uv_ff.w;
      rep_in.h     = uv_ff.h;
   end

   // fraction times size; tiling keeps the fraction, untiled 1.0 means last texel
   always_comb begin
      tex_in.valid    = rep_ff.valid;
      tex_in.col_zero = rep_ff.qu < 0;
      tex_in.row_zero = rep_ff.qv < 0;
      tex_in.col_top  = !rep_ff.tiled && (rep_ff.qu >= puti_pkg::PROD_W'(puti_pkg::UV_ONE));
      tex_in.row_top  = !rep_ff.tiled && (rep_ff.qv >= puti_pkg::PROD_W'(puti_pkg::UV_ONE));
      tex_in.col_prod = 29'(rep_ff.qu[puti_pkg::UV_FRAC-1:0]) * 29'(rep_ff.w);
      tex_in.row_prod = 29'(rep_ff.qv[puti_pkg::UV_FRAC-1:0]) * 29'(rep_ff.h);
      tex_in.w        = rep_ff.w;
      tex_in.h        = rep_ff.h;
   end

   // column and row
   always_comb begin
      cr_in.valid = tex_ff.valid;
      cr_in.w     = tex_ff.w;
      if (tex_ff.col_zero) begin
         cr_in.col = '0;
      end else if (tex_ff.col_top) begin
         cr_in.col = puti_pkg::TEXEL_W'(tex_ff.w - puti_pkg::DIM_W'(1));
      end else begin
         cr_in.col = tex_ff.col_prod[puti_pkg::UV_FRAC +: puti_pkg::TEXEL_W];
      end
      if (tex_ff.row_zero) begin
         cr_in.row = '0;
      end else if (tex_ff.row_top) begin
         cr_in.row = puti_pkg::TEXEL_W'(tex_ff.h - puti_pkg::DIM_W'(1));
      end else begin
         cr_in.row = tex_ff.row_prod[puti_pkg::UV_FRAC +: puti_pkg::TEXEL_W];
      end
   end

   // row-major index
   always_comb begin
      out_valid_in        = cr_ff.valid;
      out_in.texel_index  = puti_pkg::INDEX_W'(cr_ff.row) * puti_pkg::INDEX_W'(cr_ff.w)
                            + puti_pkg::INDEX_W'(cr_ff.col);
      out_in.texel_column = cr_ff.col;
      out_in.texel_row    = cr_ff.row;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         uv_ff        <= '0;
         rep_ff       <= '0;
         tex_ff       <= '0;
         cr_ff        <= '0;
         out_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         uv_ff        <= uv_in;
         rep_ff       <= rep_in;
         tex_ff       <= tex_in;
         cr_ff        <= cr_in;
         out_ff       <= out_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

>>> rtl/puti_angle.sv
// Pipelined vectoring CORDIC: atan2(y, x) in 1/65536 turn, wrapped into (-half, +half].
// Depends on puti_pkg.
`timescale 1ns / 1ps

module puti_angle (
   input  logic                                clock,
   input  logic signed [puti_pkg::COORD_W-1:0] in_x,
   input  logic signed [puti_pkg::COORD_W-1:0] in_y,
   output logic signed [puti_pkg::ANGLE_W-1:0] out_angle
);

   puti_pkg::cordic_state_type pre;
   puti_pkg::cordic_state_type stage_in [puti_pkg::CORDIC_STAGES];
   puti_pkg::cordic_state_type stage_ff [puti_pkg::CORDIC_STAGES];
   logic signed [puti_pkg::ANGLE_W-1:0] last_ang;

   // scale up, fold the left half plane onto the right
   always_comb begin
      pre.x   = puti_pkg::CORDIC_W'(in_x) <<< puti_pkg::CORDIC_SCALE;
      pre.y   = puti_pkg::CORDIC_W'(in_y) <<< puti_pkg::CORDIC_SCALE;
      pre.ang = '0;
      if (pre.x < 0) begin
         pre.ang = (pre.y >= 0) ? puti_pkg::ANGLE_W'(puti_pkg::TURN_HALF)
                                : -puti_pkg::ANGLE_W'(puti_pkg::TURN_HALF);
         pre.x   = -pre.x;
         pre.y   = -pre.y;
      end
   end

   // a few rotations per stage
   for (genvar g = 0; g < puti_pkg::CORDIC_STAGES; g++) begin : g_stage
      always_comb begin
         puti_pkg::cordic_state_type acc;
         acc = (g == 0) ? pre : stage_ff[(g == 0) ? 0 : g - 1];
         for (int k = 0; k < puti_pkg::CORDIC_PER; k++) begin
            if (g * puti_pkg::CORDIC_PER + k < puti_pkg::CORDIC_STEPS) begin
               acc = puti_pkg::cordic_step(acc, g * puti_pkg::CORDIC_PER + k);
            end
         end
         stage_in[g] = acc;
      end

      always_ff @(posedge clock) begin
         stage_ff[g] <= stage_in[g];
      end
   end

   // wrap into (-half, +half]
   always_comb begin
      last_ang = stage_ff[puti_pkg::CORDIC_STAGES-1].ang;
      if (last_ang > puti_pkg::ANGLE_W'(puti_pkg::TURN_HALF)) begin
         last_ang = last_ang - puti_pkg::ANGLE_W'(puti_pkg::TURN_FULL);
      end
      if (last_ang <= -puti_pkg::ANGLE_W'(puti_pkg::TURN_HALF)) begin
         last_ang = last_ang + puti_pkg::ANGLE_W'(puti_pkg::TURN_FULL);
      end
      out_angle = last_ang;
   end

endmodule

>>> bench/primitive_uv_texel_index_top_test.sv
// Testbench for primitive_uv_texel_index_top: directed table, then random hit points, each result
// checked against a typed-in expected texel or a behavioral texel predictor. Depends on puti_pkg.
`timescale 1ns / 1ps

module primitive_uv_texel_index_top_test;

   localparam int N_RANDOM    = 1630;
   localparam int WATCHDOG    = 2000;
   localparam int DRAIN_WAIT  = 40;
   localparam int CALM_ITEMS  = 200;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   puti_pkg::req_type req_data = '0;
   logic              rsp_valid;
   puti_pkg::rsp_type rsp_data;

   // pending texel results, oldest first
   puti_pkg::rsp_type texel_queue[$];
   int      mismatch_count = 0;
   int      idle_cycles = 0;
   bit      timed_out = 1'b0;

   primitive_uv_texel_index_top u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   // clock, 2 ns period
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // floor division by 2^s on signed values
   function automatic longint floor_shr(longint v, int s);
      return v >>> s;
   endfunction

   // vectoring CORDIC, angle in 1/65536 turn, wrapped into (-half, +half]
   function automatic longint hit_angle(longint xa, longint ya);
      longint ang, dx, dy;
      longint steps[15] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1};
      ang = 0;
      xa = xa * 64'sd16777216;
      ya = ya * 64'sd16777216;
      if (xa < 0) begin
         ang = (ya >= 0) ? puti_pkg::TURN_HALF : -puti_pkg::TURN_HALF;
         xa = -xa;
         ya = -ya;
      end
      for (int i = 0; i < 15; i++) begin
         dx = floor_shr(ya, i);
         dy = floor_shr(xa, i);
         if (ya > 0) begin
            xa += dx; ya -= dy; ang += steps[i];
         end else begin
            xa -= dx; ya += dy; ang -= steps[i];
         end
      end
      if (ang > puti_pkg::TURN_HALF) ang -= puti_pkg::TURN_FULL;
      if (ang <= -puti_pkg::TURN_HALF) ang += puti_pkg::TURN_FULL;
      return ang;
   endfunction

   function automatic longint around_u(longint xr, longint zr);
      longint ang;
      if (xr == 0 && zr == 0) return puti_pkg::UV_HALF;
      ang = hit_angle(xr, zr);
      return (ang < 0) ? -ang : puti_pkg::UV_ONE - ang;
   endfunction

   function automatic longint int_sqrt(longint n);
      longint res, b;
      res = 0;
      b = 64'sd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic longint latitude_v(longint y16);
      longint s, c;
      s = 2 * y16;
      if (s > puti_pkg::UV_ONE) s = puti_pkg::UV_ONE;
      if (s < -puti_pkg::UV_ONE) s = -puti_pkg::UV_ONE;
      c = int_sqrt(longint'(puti_pkg::UV_ONE) * puti_pkg::UV_ONE - s * s);
      return 2 * hit_angle(c, s) + puti_pkg::UV_HALF;
   endfunction

   // texel that a hit point lands on
   function automatic puti_pkg::rsp_type texel_of(puti_pkg::req_type r);
      longint xr, yr, zr, x, y, z, w, h, ru, rv, u, v, a, b, col, row, tv;
      puti_pkg::rsp_type o;
      xr = longint'(r.coord_x);
      yr = longint'(r.coord_y);
      zr = longint'(r.coord_z);
      x = xr * 4; y = yr * 4; z = zr * 4;
      w = r.tex_width;
      if (w < 1) w = 1;
      if (w > puti_pkg::MAX_TEX_DIM) w = puti_pkg::MAX_TEX_DIM;
      h = r.tex_height;
      if (h < 1) h = 1;
      if (h > puti_pkg::MAX_TEX_DIM) h = puti_pkg::MAX_TEX_DIM;
      ru = r.repeat_u;
      rv = r.repeat_v;
      if (r.mode[1]) begin
         if (r.face >= puti_pkg::FACE_CAP_MIN) begin
            u = x + puti_pkg::UV_HALF; v = z + puti_pkg::UV_HALF;
         end else begin
            u = around_u(xr, zr); v = y + puti_pkg::UV_HALF;
         end
      end else if (r.mode == puti_pkg::MODE_SPHERE) begin
         u = around_u(xr, zr);
         v = latitude_v(y);
      end else begin
         case (r.face)
            puti_pkg::FACE_POS_X: begin a = -z; b = y;  end
            puti_pkg::FACE_NEG_X: begin a = z;  b = y;  end
            puti_pkg::FACE_POS_Y: begin a = x;  b = -z; end
            puti_pkg::FACE_NEG_Y: begin a = x;  b = z;  end
            puti_pkg::FACE_POS_Z: begin a = x;  b = y;  end
            puti_pkg::FACE_NEG_Z: begin a = -x; b = y;  end
            default:              begin a = 0;  b = 0;  end
         endcase
         u = a + puti_pkg::UV_HALF; v = b + puti_pkg::UV_HALF;
      end
      if (u > puti_pkg::UV_ONE) u = puti_pkg::UV_ONE;
      if (v < 0) v = 0;
      if (ru != 1 || rv != 1) begin
         col = floor_shr(u * ru * w, 16) % w;
         row = floor_shr((puti_pkg::UV_ONE - v) * rv * h, 16) % h;
      end else begin
         tv = puti_pkg::UV_ONE - v;
         if (tv < 0) tv = 0;
         col = floor_shr(u * w, 16);
         row = floor_shr(tv * h, 16);
      end
      if (col < 0) col = 0;
      if (col > w - 1) col = w - 1;
      if (row < 0) row = 0;
      if (row > h - 1) row = h - 1;
      o.texel_index  = puti_pkg::INDEX_W'(row * w + col);
      o.texel_column = puti_pkg::TEXEL_W'(col);
      o.texel_row    = puti_pkg::TEXEL_W'(row);
      return o;
   endfunction

   // result checker and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            if (texel_queue.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected texel result %h", rsp_data);
            end else begin : check_one
               puti_pkg::rsp_type exp_rsp;
               exp_rsp = texel_queue.pop_front();
               if (rsp_data.texel_index !== exp_rsp.texel_index ||
                   rsp_data.texel_column !== exp_rsp.texel_column ||
                   rsp_data.texel_row !== exp_rsp.texel_row) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"texel mismatch: exp idx %0d col %0d row %0d, ",
                               "got idx %0d col %0d row %0d"},
                        exp_rsp.texel_index, exp_rsp.texel_column, exp_rsp.texel_row,
                        rsp_data.texel_index, rsp_data.texel_column, rsp_data.texel_row);
               end
            end
         end
         if (rsp_valid || (start && !busy)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG) timed_out <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (timed_out) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic puti_pkg::req_type make_req(logic [1:0] m, logic [2:0] f,
                                                  int cx, int cy, int cz,
                                                  int tw, int th, int rpu, int rpv);
      puti_pkg::req_type r;
      r.mode = m; r.face = f;
      r.coord_x = puti_pkg::RAW_W'(cx);
      r.coord_y = puti_pkg::RAW_W'(cy);
      r.coord_z = puti_pkg::RAW_W'(cz);
      r.tex_width = puti_pkg::DIM_W'(tw); r.tex_height = puti_pkg::DIM_W'(th);
      r.repeat_u = 8'(rpu); r.repeat_v = 8'(rpv);
      return r;
   endfunction

   function automatic int rand_coord();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 65535) - 32768;
         1: return $urandom_range(0, 1) ? 32767 : -32768;
         2: return 0;
         default: return $urandom_range(0, 16384) - 8192;
      endcase
   endfunction

   function automatic int rand_dim();
      case ($urandom_range(0, 7))
         0: return $urandom_range(0, 8191);
         1: return $urandom_range(0, 1) ? 4096 : 1;
         default: return $urandom_range(1, 512);
      endcase
   endfunction

   function automatic int rand_repeat();
      case ($urandom_range(0, 3))
         0, 1: return 1;
         2: return $urandom_range(0, 255);
         default: return $urandom_range(2, 4);
      endcase
   endfunction

   // send one request and queue its expected texel
   task automatic send_req(puti_pkg::req_type r, bit has_exp, puti_pkg::rsp_type exp_rsp);
      req_data <= r;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      texel_queue = {texel_queue, (has_exp ? exp_rsp : texel_of(r))};
   endtask

   task automatic idle_burst();
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clock);
   endtask

   typedef struct {
      puti_pkg::req_type r;
      bit                has_exp;
      puti_pkg::rsp_type exp_rsp;
   } stim_row_type;

   stim_row_type stim_rows[$];

   initial begin
      puti_pkg::req_type r;
      stim_row_type s;
      int n;
      // directed rows: expected typed in only where it is plain
      s.has_exp = 1'b1;
      s.r = make_req(puti_pkg::MODE_CUBE, puti_pkg::FACE_POS_Z, 0, 0, 0, 1, 1, 1, 1);
      s.exp_rsp = '{texel_index: 0, texel_column: 0, texel_row: 0};
      stim_rows = {stim_rows, s};
      s.r = make_req(puti_pkg::MODE_CUBE, 3'd6, 100, 200, 300, 4, 4, 1, 1);
      s.exp_rsp = '{texel_index: 10, texel_column: 2, texel_row: 2};
      stim_rows = {stim_rows, s};
      s.r = make_req(puti_pkg::MODE_CUBE, 3'd7, 0, 0, 0, 0, 8191, 1, 1);
      s.exp_rsp = '{texel_index: 2048, texel_column: 0, texel_row: 2048};
      stim_rows = {stim_rows, s};
      s.r = make_req(puti_pkg::MODE_CUBE, puti_pkg::FACE_POS_Z, 32767, 32767, 0,
                     4096, 4096, 1, 1);
      s.exp_rsp = '{texel_index: 4095, texel_column: 4095, texel_row: 0};
      stim_rows = {stim_rows, s};
      s.r = make_req(puti_pkg::MODE_CUBE, puti_pkg::FACE_POS_Z, -32768, -32768, 0,
                     4096, 4096, 1, 1);
      s.exp_rsp = '{texel_index: 16777215 & ((4095 * 4096)), texel_column: 0, texel_row: 4095};
      stim_rows = {stim_rows, s};
      s.r = make_req(puti_pkg::MODE_CUBE, puti_pkg::FACE_POS_Z, 0, 0, 0, 8, 8, 0, 0);
      s.exp_rsp = '{texel_index: 0, texel_column: 0, texel_row: 0};
      stim_rows = {stim_rows, s};
      s.has_exp = 1'b0;
      for (int f = 0; f < 8; f++) begin
         s.r = make_req(puti_pkg::MODE_CUBE, 3'(f), 3000, -5000, 7000, 64, 32, 1, 1);
         stim_rows = {stim_rows, s};
      end
      for (int m = 1; m < 4; m++)
         for (int f = 0; f < 4; f += 3) begin
            s.r = make_req(2'(m), 3'(f), -4000, 2500, 6000, 256, 128, 1, 1);
            stim_rows = {stim_rows, s};
         end
      s.r = make_req(puti_pkg::MODE_SPHERE, 3'd0, 0, 32767, 0, 100, 100, 1, 1);
      stim_rows = {stim_rows, s};
      s.r = make_req(puti_pkg::MODE_SPHERE, 3'd0, 0, -32768, 0, 100, 100, 3, 2);
      stim_rows = {stim_rows, s};
      s.r = make_req(puti_pkg::MODE_CYLINDER, 3'd1, -8192, 0, -1, 4096, 1, 255, 255);
      stim_rows = {stim_rows, s};
      s.r = make_req(2'd3, 3'd5, 5000, 100, -5000, 300, 200, 7, 1);
      stim_rows = {stim_rows, s};
      s.r = make_req(puti_pkg::MODE_SPHERE, 3'd2, -100, 0, 0, 4097, 5000, 1, 9);
      stim_rows = {stim_rows, s};

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_rows[i]) begin
         send_req(stim_rows[i].r, stim_rows[i].has_exp, stim_rows[i].exp_rsp);
         if ($urandom_range(0, 3) == 0) idle_burst();
      end

      // hold off until the pipe is empty
      start <= 1'b0;
      while (texel_queue.size() != 0) @(posedge clock);

      n = 0;
      while (n < N_RANDOM) begin
         r.mode = 2'($urandom_range(0, 3));
         r.face = 3'($urandom_range(0, 7));
         r.coord_x = puti_pkg::RAW_W'(rand_coord());
         r.coord_y = puti_pkg::RAW_W'(rand_coord());
         r.coord_z = puti_pkg::RAW_W'(rand_coord());
         r.tex_width = puti_pkg::DIM_W'(rand_dim());
         r.tex_height = puti_pkg::DIM_W'(rand_dim());
         r.repeat_u = 8'(rand_repeat());
         r.repeat_v = 8'(rand_repeat());
         send_req(r, 1'b0, '0);
         n++;
         if (n < N_RANDOM - CALM_ITEMS && $urandom_range(0, 4) == 0) idle_burst();
      end
      start <= 1'b0;

      // drain
      while (texel_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0 && texel_queue.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

>>> files.f
rtl/puti_pkg.sv
rtl/puti_angle.sv
rtl/primitive_uv_texel_index_top.sv
bench/primitive_uv_texel_index_top_test.sv
